// ===== hw/rtl/download_frame_receiver_macros.svh =====
// Assertion macros used by the download frame receiver core.
`ifndef DOWNLOAD_FRAME_RECEIVER_MACROS_SVH
`define DOWNLOAD_FRAME_RECEIVER_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define DFR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define DFR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hw/rtl/dfr_pkg.sv =====
// Shared types and constants for the download frame receiver.
`default_nettype none

package dfr_pkg;

  localparam int unsigned HdrCntW = 4;

  // Header byte count that marks the data phase, and the last header byte.
  localparam logic [HdrCntW-1:0] HdrDone = 4'd8;
  localparam logic [HdrCntW-1:0] HdrLast = 4'd7;

  // Smallest legal total frame length: eight header bytes plus the trailer.
  localparam logic [31:0] MinFrameLen = 32'd10;

  // Byte held in the input register.
  typedef struct packed {
    logic       valid;
    logic [7:0] data_byte;
  } in_stage_t;

  // One result item.
  typedef struct packed {
    logic        write_valid;
    logic [31:0] write_address;
    logic [7:0]  write_data;
    logic        frame_done;
    logic        checksum_ok;
    logic        length_error;
    logic [31:0] start_address;
    logic [15:0] computed_sum;
    logic [15:0] received_sum;
  } result_t;

endpackage

`default_nettype wire

// ===== hw/rtl/dfr_in_reg.sv =====
// Input register stage that takes one stream byte per request.
`default_nettype none

module dfr_in_reg (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_ready_o,
  input  wire logic [7:0]         data_byte_i,
  input  wire logic               advance_i,
  output dfr_pkg::in_stage_t      stage_o
);

  logic       valid_q;
  logic       valid_d;
  logic [7:0] byte_q;

  // The stage frees up when its byte moves on into the result register.
  assign in_ready_o = !valid_q || advance_i;
  assign valid_d    = in_ready_o ? in_valid_i : valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      byte_q <= data_byte_i;
    end
  end

  assign stage_o.valid     = valid_q;
  assign stage_o.data_byte = byte_q;

endmodule

`default_nettype wire

// ===== hw/rtl/dfr_core.sv =====
// Frame parser, checksum and result register of the download frame receiver.
`default_nettype none

`include "download_frame_receiver_macros.svh"

module dfr_core (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire dfr_pkg::in_stage_t  stage_i,
  output logic                     advance_o,
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output dfr_pkg::result_t         result_o
);

  logic [dfr_pkg::HdrCntW-1:0] hdr_q, hdr_d;
  logic [31:0]                 la_q, la_d;
  logic [31:0]                 tl_q, tl_d;
  logic [31:0]                 plen_q, plen_d;
  logic [31:0]                 off_q, off_d;
  logic [15:0]                 sum_q, sum_d;
  logic [7:0]                  trl_q, trl_d;
  logic                        out_valid_q;
  dfr_pkg::result_t            res_q, res_d;
  logic                        load;
  logic [31:0]                 tl_full;
  logic [4:0]                  lane_sh;
  logic [15:0]                 rx_sum;
  logic [7:0]                  b;

  assign advance_o = !out_valid_q || out_ready_i;
  assign load      = stage_i.valid && advance_o;
  assign b         = stage_i.data_byte;
  assign lane_sh   = {hdr_q[1:0], 3'b000};
  assign tl_full   = {b, tl_q[23:0]};
  assign rx_sum    = {b, trl_q};

  always_comb begin
    hdr_d  = hdr_q;
    la_d   = la_q;
    tl_d   = tl_q;
    plen_d = plen_q;
    off_d  = off_q;
    sum_d  = sum_q;
    trl_d  = trl_q;
    res_d  = '0;
    if (load) begin
      if (!hdr_q[3]) begin
        // Header bytes fill their fields little-endian; no write is issued.
        if (!hdr_q[2]) begin
          la_d[lane_sh +: 8] = b;
        end else begin
          tl_d[lane_sh +: 8] = b;
        end
        hdr_d = hdr_q + 4'd1;
        if (hdr_q == dfr_pkg::HdrLast) begin
          if (tl_full < dfr_pkg::MinFrameLen) begin
            res_d.frame_done    = 1'b1;
            res_d.length_error  = 1'b1;
            res_d.start_address = la_q;
            hdr_d  = '0;
            la_d   = '0;
            tl_d   = '0;
            plen_d = '0;
          end else begin
            plen_d = tl_full - dfr_pkg::MinFrameLen;
          end
        end
      end else begin
        res_d.write_valid   = 1'b1;
        res_d.write_address = la_q + off_q;
        res_d.write_data    = b;
        if (off_q < plen_q) begin
          sum_d = sum_q + {8'd0, b};
          off_d = off_q + 32'd1;
        end else if (off_q == plen_q) begin
          trl_d = b;
          off_d = off_q + 32'd1;
        end else begin
          // Second trailer byte closes the frame and rearms for a header.
          res_d.frame_done    = 1'b1;
          res_d.checksum_ok   = (rx_sum == sum_q);
          res_d.start_address = la_q;
          res_d.computed_sum  = sum_q;
          res_d.received_sum  = rx_sum;
          hdr_d  = '0;
          la_d   = '0;
          tl_d   = '0;
          plen_d = '0;
          off_d  = '0;
          sum_d  = '0;
          trl_d  = '0;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      hdr_q       <= '0;
      la_q        <= '0;
      tl_q        <= '0;
      plen_q      <= '0;
      off_q       <= '0;
      sum_q       <= '0;
      trl_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      hdr_q  <= hdr_d;
      la_q   <= la_d;
      tl_q   <= tl_d;
      plen_q <= plen_d;
      off_q  <= off_d;
      sum_q  <= sum_d;
      trl_q  <= trl_d;
      if (advance_o) begin
        out_valid_q <= stage_i.valid;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign result_o    = res_q;

  `DFR_ASSERT_NOW(a_lenerr_is_done, out_valid_q && res_q.length_error,
    res_q.frame_done && !res_q.checksum_ok && !res_q.write_valid,
    "length error without a clean frame end")
  `DFR_ASSERT_NOW(a_ok_needs_done, out_valid_q && res_q.checksum_ok,
    res_q.frame_done, "checksum_ok outside a frame end")
  `DFR_ASSERT_NEXT(a_rearm_after_done, load && res_d.frame_done,
    hdr_q == '0 && off_q == '0 && sum_q == '0, "no rearm after frame end")
  `DFR_ASSERT_NOW(a_write_in_data_phase, load && res_d.write_valid,
    hdr_q == dfr_pkg::HdrDone, "write issued during the header")
  `DFR_ASSERT_NEXT(a_result_holds, out_valid_q && !out_ready_i,
    out_valid_q && $stable(res_q), "stalled result changed")

endmodule

`default_nettype wire

// ===== hw/rtl/download_frame_receiver.sv =====
// A byte in the input register moves into the result register unless the output is stalled.
// Throughput: one byte per cycle while the output is not stalled; the per-byte work is one
// offset counter, one address adder, two offset compares and the 16-bit checksum adder.
// A stalled output still lets one more byte into the input register.
// Reset (rst_ni low, asynchronous) empties both registers and rearms for a header.
`default_nettype none

module download_frame_receiver (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_ready_o,
  input  wire logic [7:0]  data_byte_i,
  output logic             out_valid_o,
  input  wire logic        out_ready_i,
  output logic             write_valid_o,
  output logic [31:0]      write_address_o,
  output logic [7:0]       write_data_o,
  output logic             frame_done_o,
  output logic             checksum_ok_o,
  output logic             length_error_o,
  output logic [31:0]      start_address_o,
  output logic [15:0]      computed_sum_o,
  output logic [15:0]      received_sum_o
);

  dfr_pkg::in_stage_t stage;
  dfr_pkg::result_t   result;
  logic               advance;

  dfr_in_reg u_in_reg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .data_byte_i (data_byte_i),
    .advance_i   (advance),
    .stage_o     (stage)
  );

  dfr_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .stage_i     (stage),
    .advance_o   (advance),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .result_o    (result)
  );

  assign write_valid_o   = result.write_valid;
  assign write_address_o = result.write_address;
  assign write_data_o    = result.write_data;
  assign frame_done_o    = result.frame_done;
  assign checksum_ok_o   = result.checksum_ok;
  assign length_error_o  = result.length_error;
  assign start_address_o = result.start_address;
  assign computed_sum_o  = result.computed_sum;
  assign received_sum_o  = result.received_sum;

endmodule

`default_nettype wire
